/* sv/lrast_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared types and constants of the lazy range-add / range-sum tree.
// ----------------------------------------------------------------------------
package lrast_pkg;

  localparam int MAX_ELEMS_DEF  = 1024;
  localparam int TREE_NODES_DEF = 2048;

  localparam int KIND_W  = 2;
  localparam int IDX_W   = 10;
  localparam int AMT_W   = 64;
  localparam int COUNT_W = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUM  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_ELEM_COUNT = 1'b0;

  localparam logic [1:0] PH_ENTER = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_COV_RD,
    ST_COV_WR,
    ST_PD_RD,
    ST_PD_P,
    ST_PD_A_RD,
    ST_PD_A_WR,
    ST_PD_B_RD,
    ST_PD_B_WR,
    ST_PD_S_WR,
    ST_CH_RDA,
    ST_CH_RDB,
    ST_CH_WR,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_SELF,
    ADDR_LEFT,
    ADDR_RIGHT,
    ADDR_CLEAR
  } addr_sel_t;

  typedef enum logic [1:0] {
    SUMW_PROD,
    SUMW_RECOMP,
    SUMW_ZERO
  } sum_wsel_t;

  typedef enum logic [1:0] {
    PENDW_AMOUNT,
    PENDW_PVAL,
    PENDW_ZERO
  } pend_wsel_t;

  typedef enum logic [1:0] {
    MUL_COV,
    MUL_LEFT,
    MUL_RIGHT
  } mul_sel_t;

  typedef struct packed {
    logic       load_item;
    logic       clear_step;
    logic       push_left;
    logic       push_right;
    logic       pop;
    addr_sel_t  addr_sel;
    logic       sum_we;
    sum_wsel_t  sum_wsel;
    logic       pend_we;
    pend_wsel_t pend_wsel;
    mul_sel_t   mul_sel;
    logic       take_p;
    logic       hold_tmp;
    logic       acc_add;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       empty;
    logic [1:0] phase;
    logic       disjoint;
    logic       covered;
    logic       p_zero;
    logic       is_sum;
    logic       out_full;
  } sts_t;

endpackage
`default_nettype wire

/* sv/lrast_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_in_if
// Request channel: operation kind, range bounds and amount.
// ----------------------------------------------------------------------------
interface lrast_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [lrast_pkg::KIND_W-1:0]         kind;
  logic [lrast_pkg::IDX_W-1:0]          range_lo;
  logic [lrast_pkg::IDX_W-1:0]          range_hi;
  logic signed [lrast_pkg::AMT_W-1:0]   amount;

  modport source(output valid, kind, range_lo, range_hi, amount, input ready);
  modport sink(input valid, kind, range_lo, range_hi, amount, output ready);
endinterface
`default_nettype wire

/* sv/lrast_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_out_if
// Result channel: sum over the queried range.
// ----------------------------------------------------------------------------
interface lrast_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lrast_pkg::AMT_W-1:0]   range_sum;

  modport source(output valid, range_sum, input ready);
  modport sink(input valid, range_sum, output ready);
endinterface
`default_nettype wire

/* sv/lrast_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lrast_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* sv/lrast_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_ctrl
// Sequencer for the tree walk: clear, visit, push-down and recompute steps.
// ----------------------------------------------------------------------------
module lrast_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lrast_pkg::sts_t sts,
  output lrast_pkg::cmd_t      cmd
);
  import lrast_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.addr_sel  = ADDR_SELF;
    cmd.sum_wsel  = SUMW_PROD;
    cmd.pend_wsel = PENDW_AMOUNT;
    cmd.mul_sel   = MUL_COV;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        cmd.addr_sel   = ADDR_CLEAR;
        cmd.sum_we     = 1'b1;
        cmd.sum_wsel   = SUMW_ZERO;
        cmd.pend_we    = 1'b1;
        cmd.pend_wsel  = PENDW_ZERO;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_VISIT;
        end
      end
      ST_VISIT: begin
        cmd.mul_sel = MUL_COV;
        if (sts.empty) begin
          state_next = sts.is_sum ? ST_EMIT : ST_IDLE;
        end else begin
          case (sts.phase)
            PH_ENTER: begin
              if (sts.disjoint) begin
                cmd.pop = 1'b1;
              end else if (sts.covered) begin
                state_next = ST_COV_RD;
              end else begin
                state_next = ST_PD_RD;
              end
            end
            PH_LEFT: begin
              cmd.push_right = 1'b1;
            end
            default: begin
              if (sts.is_sum) begin
                cmd.pop = 1'b1;
              end else begin
                state_next = ST_CH_RDA;
              end
            end
          endcase
        end
      end
      ST_COV_RD: begin
        state_next = ST_COV_WR;
      end
      ST_COV_WR: begin
        if (sts.is_sum) begin
          cmd.acc_add = 1'b1;
        end else begin
          cmd.sum_we  = 1'b1;
          cmd.pend_we = 1'b1;
        end
        cmd.pop    = 1'b1;
        state_next = ST_VISIT;
      end
      ST_PD_RD: begin
        state_next = ST_PD_P;
      end
      ST_PD_P: begin
        cmd.take_p  = 1'b1;
        cmd.mul_sel = MUL_LEFT;
        if (sts.p_zero) begin
          cmd.push_left = 1'b1;
          state_next    = ST_VISIT;
        end else begin
          state_next = ST_PD_A_RD;
        end
      end
      ST_PD_A_RD: begin
        // hold the left product; the store still returns this node's add
        cmd.addr_sel = ADDR_LEFT;
        cmd.mul_sel  = MUL_LEFT;
        state_next   = ST_PD_A_WR;
      end
      ST_PD_A_WR: begin
        cmd.addr_sel  = ADDR_LEFT;
        cmd.sum_we    = 1'b1;
        cmd.pend_we   = 1'b1;
        cmd.pend_wsel = PENDW_PVAL;
        cmd.mul_sel   = MUL_RIGHT;
        state_next    = ST_PD_B_RD;
      end
      ST_PD_B_RD: begin
        cmd.addr_sel = ADDR_RIGHT;
        cmd.mul_sel  = MUL_RIGHT;
        state_next   = ST_PD_B_WR;
      end
      ST_PD_B_WR: begin
        cmd.addr_sel  = ADDR_RIGHT;
        cmd.sum_we    = 1'b1;
        cmd.pend_we   = 1'b1;
        cmd.pend_wsel = PENDW_PVAL;
        state_next    = ST_PD_S_WR;
      end
      ST_PD_S_WR: begin
        cmd.pend_we   = 1'b1;
        cmd.pend_wsel = PENDW_ZERO;
        cmd.push_left = 1'b1;
        state_next    = ST_VISIT;
      end
      ST_CH_RDA: begin
        cmd.addr_sel = ADDR_LEFT;
        state_next   = ST_CH_RDB;
      end
      ST_CH_RDB: begin
        cmd.addr_sel = ADDR_RIGHT;
        cmd.hold_tmp = 1'b1;
        state_next   = ST_CH_WR;
      end
      ST_CH_WR: begin
        cmd.sum_we   = 1'b1;
        cmd.sum_wsel = SUMW_RECOMP;
        cmd.pop      = 1'b1;
        state_next   = ST_VISIT;
      end
      ST_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

/* sv/lrast_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_dpath
// Walk stack, node stores, multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
module lrast_dpath #(
  parameter int MAX_ELEMS  = lrast_pkg::MAX_ELEMS_DEF,
  parameter int TREE_NODES = lrast_pkg::TREE_NODES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire lrast_pkg::cmd_t                    cmd,
  output lrast_pkg::sts_t                         sts,
  input  wire logic [lrast_pkg::COUNT_W-1:0]      elem_count,
  input  wire logic [lrast_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [lrast_pkg::IDX_W-1:0]        in_lo,
  input  wire logic [lrast_pkg::IDX_W-1:0]        in_hi,
  input  wire logic [lrast_pkg::AMT_W-1:0]        in_amount,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [lrast_pkg::AMT_W-1:0]             out_sum
);
  import lrast_pkg::*;

  localparam int IW  = $clog2(MAX_ELEMS);
  localparam int NW  = IW + 2;
  localparam int AW  = $clog2(TREE_NODES);
  localparam int CW  = (IW > IDX_W) ? IW : IDX_W;
  localparam int SD  = 1 << $clog2(IW + 3);
  localparam int XW  = $clog2(SD);

  // walk stack
  logic [NW-1:0] st_node [SD];
  logic [IW-1:0] st_l    [SD];
  logic [IW-1:0] st_r    [SD];
  logic [1:0]    st_ph   [SD];
  logic [XW:0]   sp;

  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  lo, hi;
  logic [AMT_W-1:0]  amount, pval, prod, tmp, acc;
  logic [AW-1:0]     clr_cnt;

  logic [XW-1:0] top, spi;
  logic [NW-1:0] t_node, n_left, n_right;
  logic [IW-1:0] t_l, t_r, mid, root_r;
  logic [IW:0]   mid_w, len_self, len_left, len_right, mul_b;
  logic [AMT_W-1:0] mul_a;
  logic [AW-1:0] addr, a_self, a_left, a_right;
  logic [AMT_W-1:0] sum_rd, pend_rd, sum_wd, pend_wd;

  function automatic logic [AW-1:0] slot(input logic [NW-1:0] node);
    return (32'(node) < TREE_NODES) ? AW'(node) : '0;
  endfunction

  assign spi    = sp[XW-1:0];
  assign top    = XW'(sp - 1'b1);
  assign t_node = st_node[top];
  assign t_l    = st_l[top];
  assign t_r    = st_r[top];

  assign mid_w     = ((IW+1)'(t_l) + (IW+1)'(t_r)) >> 1;
  assign mid       = mid_w[IW-1:0];
  assign len_self  = (IW+1)'(t_r) - (IW+1)'(t_l) + 1'b1;
  assign len_left  = mid_w - (IW+1)'(t_l) + 1'b1;
  assign len_right = (IW+1)'(t_r) - mid_w;
  assign n_left    = {t_node[NW-2:0], 1'b0};
  assign n_right   = {t_node[NW-2:0], 1'b1};

  assign root_r = (elem_count == '0) ? '0 :
                  (32'(elem_count) > MAX_ELEMS) ? IW'(MAX_ELEMS - 1) :
                  IW'(32'(elem_count) - 32'd1);

  assign a_self  = slot(t_node);
  assign a_left  = slot(n_left);
  assign a_right = slot(n_right);

  always_comb begin
    case (cmd.addr_sel)
      ADDR_SELF:  addr = a_self;
      ADDR_LEFT:  addr = a_left;
      ADDR_RIGHT: addr = a_right;
      default:    addr = clr_cnt;
    endcase
    case (cmd.mul_sel)
      MUL_LEFT: begin
        mul_a = pend_rd;
        mul_b = len_left;
      end
      MUL_RIGHT: begin
        mul_a = pval;
        mul_b = len_right;
      end
      default: begin
        mul_a = amount;
        mul_b = len_self;
      end
    endcase
    case (cmd.sum_wsel)
      SUMW_RECOMP: sum_wd = tmp + sum_rd;
      SUMW_ZERO:   sum_wd = '0;
      default:     sum_wd = sum_rd + prod;
    endcase
    case (cmd.pend_wsel)
      PENDW_PVAL: pend_wd = pend_rd + pval;
      PENDW_ZERO: pend_wd = '0;
      default:    pend_wd = pend_rd + amount;
    endcase
  end

  lrast_ram #(.WIDTH(AMT_W), .DEPTH(TREE_NODES)) u_sums (
    .clk   (clk),
    .addr  (addr),
    .we    (cmd.sum_we),
    .wdata (sum_wd),
    .rdata (sum_rd)
  );

  lrast_ram #(.WIDTH(AMT_W), .DEPTH(TREE_NODES)) u_pend (
    .clk   (clk),
    .addr  (addr),
    .we    (cmd.pend_we),
    .wdata (pend_wd),
    .rdata (pend_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.load_item) begin
        sp <= (in_kind == KIND_NONE) ? '0 : (XW+1)'(1);
      end else if (cmd.push_left || cmd.push_right) begin
        sp <= sp + 1'b1;
      end else if (cmd.pop) begin
        sp <= sp - 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prod <= AMT_W'(mul_a * AMT_W'(mul_b));
    if (cmd.load_item) begin
      kind       <= in_kind;
      lo         <= in_lo;
      hi         <= (in_kind == KIND_LOAD) ? in_lo : in_hi;
      amount     <= in_amount;
      acc        <= '0;
      st_node[0] <= NW'(1);
      st_l[0]    <= '0;
      st_r[0]    <= root_r;
      st_ph[0]   <= PH_ENTER;
    end
    if (cmd.push_left) begin
      st_ph[top]   <= PH_LEFT;
      st_node[spi] <= n_left;
      st_l[spi]    <= t_l;
      st_r[spi]    <= mid;
      st_ph[spi]   <= PH_ENTER;
    end
    if (cmd.push_right) begin
      st_ph[top]   <= PH_RIGHT;
      st_node[spi] <= n_right;
      st_l[spi]    <= mid + 1'b1;
      st_r[spi]    <= t_r;
      st_ph[spi]   <= PH_ENTER;
    end
    if (cmd.take_p) begin
      pval <= pend_rd;
    end
    if (cmd.hold_tmp) begin
      tmp <= sum_rd;
    end
    if (cmd.acc_add) begin
      acc <= acc + sum_rd;
    end
    if (cmd.emit) begin
      out_sum <= acc;
    end
  end

  always_comb begin
    sts.clear_done = (clr_cnt == AW'(TREE_NODES - 1));
    sts.empty      = (sp == '0);
    sts.phase      = st_ph[top];
    sts.disjoint   = (CW'(hi) < CW'(t_l)) || (CW'(t_r) < CW'(lo));
    sts.covered    = (CW'(lo) <= CW'(t_l)) && (CW'(t_r) <= CW'(hi));
    sts.p_zero     = (pend_rd == '0);
    sts.is_sum     = (kind == KIND_SUM);
    sts.out_full   = out_valid && !out_ready;
  end
endmodule
`default_nettype wire

/* sv/lazy_range_add_sum_tree.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lazy_range_add_sum_tree
// Segment tree of 64-bit sums with lazy pending adds: point load (an add to
// one element), range add and range sum over the first elem_count elements.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------
//  req      | in  | valid / ready      | kind, range_lo, range_hi, amount
//  rsp      | out | valid / ready      | range_sum (kind = sum only)
//  apb      | in  | psel/penable/pready| elem_count at byte address 0
//
//  Walk: one item at a time; a node outside the range is popped at once, a
//  covered node is updated or added into the sum, a partly covered node first
//  pushes any pending add to both children; a range add recomputes its sum.
//  Reset: a clearing pass writes zero to every node, with req.ready low;
//  configuration writes are taken throughout.
//  Stalls: a finished sum waits in the output register, the next request is
//  accepted meanwhile, and a later sum waits only if that slot is full.
// ----------------------------------------------------------------------------
module lazy_range_add_sum_tree #(
  parameter int MAX_ELEMS  = lrast_pkg::MAX_ELEMS_DEF,
  parameter int TREE_NODES = lrast_pkg::TREE_NODES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lrast_in_if.sink                             req,
  lrast_out_if.source                          rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lrast_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [lrast_pkg::PDATA_W-1:0]   pwdata,
  output logic      [lrast_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready
);
  import lrast_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [COUNT_W-1:0] elem_count;

  // Configuration register: written on the access phase of an APB transfer.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ELEM_COUNT) ? PDATA_W'(elem_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ELEM_COUNT)) begin
      elem_count <= pwdata[COUNT_W-1:0];
    end
  end

  // Sequencer: one state per memory step of the walk.
  lrast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stack, node stores, multiplier and result register.
  lrast_dpath #(
    .MAX_ELEMS  (MAX_ELEMS),
    .TREE_NODES (TREE_NODES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .elem_count (elem_count),
    .in_kind    (req.kind),
    .in_lo      (req.range_lo),
    .in_hi      (req.range_hi),
    .in_amount  (req.amount),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_sum    (rsp.range_sum)
  );
endmodule
`default_nettype wire
